// ===== rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the low-pass filter RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// ante implies cons in the same cycle
`define CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante implies cons in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dcfl_pkg.sv =====
// -----------------------------------------------------------------------------
// dcfl_pkg
// Constants, tap table and shared types of the dual-channel FIR low-pass.
// -----------------------------------------------------------------------------
package dcfl_pkg;

  localparam int TAP_COUNT_DEF   = 51;
  localparam int SAMPLE_BITS_DEF = 16;

  // taps are signed Q1.17
  localparam int COEF_BITS = 18;
  localparam int FRAC_BITS = COEF_BITS - 1;

  localparam int TABLE_LEN = 51;
  localparam int TAB_IDX_W = 6;
  localparam int TAP_IDX_W = 8;

  localparam logic signed [COEF_BITS-1:0] TAP_TABLE [TABLE_LEN] = '{
    18'sd0,    18'sd22,   18'sd50,   18'sd93,   18'sd155,  18'sd244,
    18'sd364,  18'sd522,  18'sd720,  18'sd962,  18'sd1247, 18'sd1573,
    18'sd1939, 18'sd2338, 18'sd2763, 18'sd3206, 18'sd3656, 18'sd4102,
    18'sd4532, 18'sd4935, 18'sd5299, 18'sd5613, 18'sd5868, 18'sd6056,
    18'sd6171, 18'sd6210, 18'sd6171, 18'sd6056, 18'sd5868, 18'sd5613,
    18'sd5299, 18'sd4935, 18'sd4532, 18'sd4102, 18'sd3656, 18'sd3206,
    18'sd2763, 18'sd2338, 18'sd1939, 18'sd1573, 18'sd1247, 18'sd962,
    18'sd720,  18'sd522,  18'sd364,  18'sd244,  18'sd155,  18'sd93,
    18'sd50,   18'sd22,   18'sd0
  };

  // taps past the end of the table are zero
  function automatic logic signed [COEF_BITS-1:0] tap_coef(
    input logic [TAP_IDX_W-1:0] idx
  );
    logic signed [COEF_BITS-1:0] r;
    r = '0;
    if (idx < TAP_IDX_W'(TABLE_LEN)) begin
      r = TAP_TABLE[idx[TAB_IDX_W-1:0]];
    end
    return r;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // controls for one multiply-accumulate lane
  typedef struct packed {
    logic clear;   // start of a new item
    logic mul_en;  // read data and tap valid
    logic zero;    // entry not yet filled, use zero
    logic acc_en;  // product register valid
  } mac_ctl_t;

endpackage

// ===== rtl/dual_channel_fir_lowpass_unit.sv =====
// -----------------------------------------------------------------------------
// dual_channel_fir_lowpass_unit
// Dual-channel (red / infrared) symmetric low-pass FIR with fixed Q1.17 taps.
// -----------------------------------------------------------------------------
// Each input transfer carries one red and one infrared sample; each produces
// one output transfer with both filtered values, rounded half up and saturated.
// The delay lines are circular buffers in two RAMs sharing one address. One tap
// per cycle is read from the single read port and fed to a registered
// multiply-accumulate per channel; the sum passes the RAM read register, the
// product register and the accumulator before it is rounded into the output
// register. The next input is taken only once the result has moved to the
// output register, so the block takes no new sample pair while one is in work,
// and it waits while the output register is held by the receiver. A fill count
// makes unwritten entries read as zero, so no clearing pass follows reset.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_channel_fir_lowpass_unit #(
  parameter int TAP_COUNT   = dcfl_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_BITS = dcfl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_red,
  input  logic signed [SAMPLE_BITS-1:0] sample_ir,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] filtered_red,
  output logic signed [SAMPLE_BITS-1:0] filtered_ir
);

  localparam int AW = $clog2(TAP_COUNT);
  localparam int FW = $clog2(TAP_COUNT + 1);

  dcfl_pkg::state_t state, state_next;

  logic [AW-1:0] k;
  logic [AW-1:0] wp;
  logic [AW-1:0] rd_addr;
  logic [FW-1:0] fill;

  logic                                  s1_valid;
  logic                                  s1_zero;
  logic                                  p_valid;
  logic signed [dcfl_pkg::COEF_BITS-1:0] s1_tap;

  logic accept;
  logic rd_en;
  logic load_out;

  logic signed [SAMPLE_BITS-1:0] red_rdata, ir_rdata;
  logic signed [SAMPLE_BITS-1:0] red_res, ir_res;

  dcfl_pkg::mac_ctl_t ctl;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      dcfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = dcfl_pkg::ST_RUN;
        end
      end
      dcfl_pkg::ST_RUN: begin
        rd_en = 1'b1;
        if (k == AW'(TAP_COUNT - 1)) begin
          state_next = dcfl_pkg::ST_DRAIN;
        end
      end
      dcfl_pkg::ST_DRAIN: begin
        if (!s1_valid && !p_valid && (!out_valid || out_ready)) begin
          load_out   = 1'b1;
          state_next = dcfl_pkg::ST_IDLE;
        end
      end
      default: state_next = dcfl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dcfl_pkg::ST_IDLE;
      k         <= '0;
      wp        <= '0;
      rd_addr   <= '0;
      fill      <= '0;
      s1_valid  <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= rd_en;
      p_valid  <= s1_valid;
      if (accept) begin
        // newest sample is read first, then walk back in age
        rd_addr <= wp;
        k       <= '0;
        wp      <= (wp == AW'(TAP_COUNT - 1)) ? '0 : wp + AW'(1);
        if (fill != FW'(TAP_COUNT)) begin
          fill <= fill + FW'(1);
        end
      end else if (rd_en) begin
        k       <= k + AW'(1);
        rd_addr <= (rd_addr == '0) ? AW'(TAP_COUNT - 1) : rd_addr - AW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_tap  <= dcfl_pkg::tap_coef(dcfl_pkg::TAP_IDX_W'(k));
      s1_zero <= !(FW'(k) < fill);
    end
    if (load_out) begin
      filtered_red <= red_res;
      filtered_ir  <= ir_res;
    end
  end

  dcfl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAP_COUNT)
  ) u_red_line (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (sample_red),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (red_rdata)
  );

  dcfl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAP_COUNT)
  ) u_ir_line (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (sample_ir),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ir_rdata)
  );

  always_comb begin
    ctl.clear  = accept;
    ctl.mul_en = s1_valid;
    ctl.zero   = s1_zero;
    ctl.acc_en = p_valid;
  end

  dcfl_mac #(
    .TAP_COUNT   (TAP_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_red_mac (
    .clk    (clk),
    .ctl    (ctl),
    .tap    (s1_tap),
    .sample (red_rdata),
    .result (red_res)
  );

  dcfl_mac #(
    .TAP_COUNT   (TAP_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ir_mac (
    .clk    (clk),
    .ctl    (ctl),
    .tap    (s1_tap),
    .sample (ir_rdata),
    .result (ir_res)
  );

  `CHK_SAME(a_idle_empty, clk, rst, in_ready, !s1_valid && !p_valid)
  `CHK_ALWAYS(a_fill_range, clk, rst, fill <= FW'(TAP_COUNT))
  `CHK_ALWAYS(a_ptr_range, clk, rst, wp <= AW'(TAP_COUNT - 1) && rd_addr <= AW'(TAP_COUNT - 1))
  `CHK_NEXT(a_accept_run, clk, rst, accept, state == dcfl_pkg::ST_RUN && k == '0)

endmodule

// ===== rtl/dcfl_ram.sv =====
// -----------------------------------------------------------------------------
// dcfl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module dcfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 51
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dcfl_mac.sv =====
// -----------------------------------------------------------------------------
// dcfl_mac
// One filter lane: registered multiply, full-width accumulate, round and
// saturate of the final sum.
// -----------------------------------------------------------------------------
module dcfl_mac #(
  parameter int TAP_COUNT   = dcfl_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_BITS = dcfl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  dcfl_pkg::mac_ctl_t                    ctl,
  input  logic signed [dcfl_pkg::COEF_BITS-1:0] tap,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  output logic signed [SAMPLE_BITS-1:0]         result
);

  localparam int PW    = SAMPLE_BITS + dcfl_pkg::COEF_BITS;
  localparam int ACC_W = PW + $clog2(TAP_COUNT) + 1;
  localparam int F     = dcfl_pkg::FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd1 <<< (F - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] shifted;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      // kept out of a conditional operator so the product stays signed
      if (ctl.zero) begin
        prod <= '0;
      end else begin
        prod <= sample * tap;
      end
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + $signed({{(ACC_W-PW){prod[PW-1]}}, prod});
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd     = acc + HALF;
    shifted = rnd >>> F;
    if (shifted > SAT_HI) begin
      result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (shifted < SAT_LO) begin
      result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== test/fir_lowpass_checker.sv =====
// -----------------------------------------------------------------------------
// fir_lowpass_checker
// Watches both channels of the dual-channel low-pass and checks every result.
// -----------------------------------------------------------------------------
// Each input transfer is pushed through a private copy of the two 51-entry
// delay lines and the Q1.17 tap table. The rounded, saturated sums are queued.
// Each output transfer is compared, per field, with the oldest queued pair.
// -----------------------------------------------------------------------------
module fir_lowpass_checker (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  logic                                        in_ready,
  input  logic signed [dcfl_pkg::SAMPLE_BITS_DEF-1:0] sample_red,
  input  logic signed [dcfl_pkg::SAMPLE_BITS_DEF-1:0] sample_ir,
  input  logic                                        out_valid,
  input  logic                                        out_ready,
  input  logic signed [dcfl_pkg::SAMPLE_BITS_DEF-1:0] filtered_red,
  input  logic signed [dcfl_pkg::SAMPLE_BITS_DEF-1:0] filtered_ir,
  output int unsigned                                 fail_count,
  output int unsigned                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W            = dcfl_pkg::SAMPLE_BITS_DEF;
  localparam int TAPS         = 51;
  localparam int FRAC         = 17;
  localparam int REPORT_LIMIT = 40;
  localparam longint SAT_HI   = (longint'(1) <<< (W - 1)) - 1;
  localparam longint SAT_LO   = -(longint'(1) <<< (W - 1));

  typedef struct packed {
    logic signed [W-1:0] red;
    logic signed [W-1:0] ir;
  } filtered_pair_t;

  // symmetric low-pass, Q1.17
  int lp_taps [TAPS] = '{
    0, 22, 50, 93, 155, 244, 364, 522, 720, 962,
    1247, 1573, 1939, 2338, 2763, 3206, 3656, 4102, 4532, 4935,
    5299, 5613, 5868, 6056, 6171, 6210, 6171, 6056, 5868, 5613,
    5299, 4935, 4532, 4102, 3656, 3206, 2763, 2338, 1939, 1573,
    1247, 962, 720, 522, 364, 244, 155, 93, 50, 22,
    0
  };

  logic signed [W-1:0] red_line [TAPS];
  logic signed [W-1:0] ir_line  [TAPS];
  filtered_pair_t      filtered_q [$];
  int unsigned         errors;

  // round half up, then clamp to the sample range
  function automatic logic signed [W-1:0] round_saturate(input longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (q > SAT_HI) return W'(SAT_HI);
    if (q < SAT_LO) return W'(SAT_LO);
    return W'(q);
  endfunction

  function automatic filtered_pair_t lowpass_step(input logic signed [W-1:0] red,
                                                  input logic signed [W-1:0] ir);
    longint         acc_red;
    longint         acc_ir;
    filtered_pair_t res;
    acc_red = 0;
    acc_ir  = 0;
    for (int k = TAPS - 1; k > 0; k--) begin
      red_line[k] = red_line[k-1];
      ir_line[k]  = ir_line[k-1];
    end
    red_line[0] = red;
    ir_line[0]  = ir;
    for (int k = 0; k < TAPS; k++) begin
      acc_red += longint'(red_line[k]) * longint'(lp_taps[k]);
      acc_ir  += longint'(ir_line[k]) * longint'(lp_taps[k]);
    end
    res.red = round_saturate(acc_red);
    res.ir  = round_saturate(acc_ir);
    return res;
  endfunction

  task automatic flag_field(input string field, input int want, input int got);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    filtered_pair_t want;
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        red_line[k] = '0;
        ir_line[k]  = '0;
      end
      filtered_q.delete();
      errors = 0;
    end else begin
      // output first: a result never belongs to an input taken at the same edge
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t ns: result transfer with nothing expected, actual red %0d ir %0d",
                     $time, filtered_red, filtered_ir);
          end
        end else begin
          want = filtered_q.pop_front();
          if (filtered_red !== want.red) flag_field("filtered_red", want.red, filtered_red);
          if (filtered_ir !== want.ir) flag_field("filtered_ir", want.ir, filtered_ir);
        end
      end
      if (in_valid && in_ready) begin
        filtered_q.push_back(lowpass_step(sample_red, sample_ir));
      end
    end
    fail_count <= errors;
    pending    <= filtered_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// -----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the dual-channel FIR low-pass unit.
// -----------------------------------------------------------------------------
// A directed start covers start-up partial sums, full-scale extremes and a
// half-way rounding case; random bursts of full-range, extreme and small
// samples follow, with random input gaps and output stalls. The checker
// beside the block predicts and compares every result.
// -----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W          = dcfl_pkg::SAMPLE_BITS_DEF;
  localparam int RAND_ITEMS = 1030;
  localparam int PAUSE_AT   = 500;
  localparam int BURST_LEN  = 32;
  localparam int LONG_HOLD  = 400;
  localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};

  typedef enum int {
    MIX_FULL,
    MIX_EXTREME,
    MIX_SMALL
  } sample_mix_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [W-1:0] sample_red = '0;
  logic signed [W-1:0] sample_ir = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [W-1:0] filtered_red;
  logic signed [W-1:0] filtered_ir;
  int unsigned         fail_count;
  int unsigned         pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_channel_fir_lowpass_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_red   (sample_red),
    .sample_ir    (sample_ir),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .filtered_red (filtered_red),
    .filtered_ir  (filtered_ir)
  );

  fir_lowpass_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_red   (sample_red),
    .sample_ir    (sample_ir),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .filtered_red (filtered_red),
    .filtered_ir  (filtered_ir),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [W-1:0] pick_sample(input sample_mix_t mix);
    logic signed [W-1:0] v;
    case (mix)
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = S_MIN;
          1:       v = S_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      MIX_SMALL: begin
        v = W'($urandom_range(0, 510)) - W'(255);
      end
      default: begin
        v = W'($urandom);
      end
    endcase
    return v;
  endfunction

  task automatic send_pair(input logic signed [W-1:0] red, input logic signed [W-1:0] ir,
                           input int gap);
    in_valid   <= 1'b1;
    sample_red <= red;
    sample_ir  <= ir;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: short and long stalls, calm stretches, one long hold-off
  initial begin : receiver
    int unsigned n_out;
    int          hold;
    int          roll;
    bit          calm;
    bit          held_long;
    n_out     = 0;
    hold      = 0;
    calm      = 1'b0;
    held_long = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (out_valid && out_ready) n_out++;
      if (hold > 0) begin
        hold--;
      end else if (!held_long && n_out >= 150) begin
        // sender keeps offering, so the block fills and stalls its input
        held_long = 1'b1;
        hold      = LONG_HOLD;
      end else if (!calm) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          hold = $urandom_range(20, 60);
        end else if (roll < 15) begin
          hold = $urandom_range(1, 4);
        end
      end
      if ($urandom_range(0, 299) == 0) calm = !calm;
      out_ready <= (hold == 0);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    sample_mix_t mix;
    bit          calm;
    int          burst_left;
    int          drain;
    burst_left = 0;
    calm       = 1'b0;
    mix        = MIX_FULL;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone minimum on red: the 22 tap lands exactly half way, rounds up
    send_pair(S_MIN, S_MAX, pick_gap(1'b0));
    repeat (3) send_pair('0, '0, pick_gap(1'b0));
    send_pair(S_MAX, S_MIN, pick_gap(1'b0));
    send_pair(W'(-1), W'(1), pick_gap(1'b0));
    send_pair(W'(1), W'(-1), pick_gap(1'b0));
    for (int k = 0; k < 8; k++) begin
      send_pair(k[0] ? S_MAX : S_MIN, k[0] ? S_MIN : S_MAX, pick_gap(1'b0));
    end
    repeat (8) send_pair(S_MAX, S_MIN, pick_gap(1'b0));

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = BURST_LEN;
        mix        = sample_mix_t'($urandom_range(0, 2));
        calm       = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      send_pair(pick_sample(mix), pick_sample(mix), pick_gap(calm));
      if (n == PAUSE_AT) begin
        // sender goes quiet until every result is out
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    for (drain = 0; drain < 5000 && pending != 0; drain++) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule
